/* rtl/core/todlp_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Time-of-day literal parser package
// Shared types, character codes and helper functions for the parser front,
// the result queue and the arithmetic back end.
// ---------------------------------------------------------------------------
package todlp_pkg;

    typedef enum logic [3:0] {
        PH_START,
        PH_LO,
        PH_UP,
        PH_TOD,
        PH_LONG_LO,
        PH_LONG_UP,
        PH_HASH,
        PH_HOUR,
        PH_MIN,
        PH_SEC,
        PH_FRAC,
        PH_ERR
    } todlp_phase_t;

    typedef enum logic [1:0] {
        SUB_INIT,
        SUB_BLANK,
        SUB_SIGN,
        SUB_DIGIT
    } todlp_sub_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_CALC,
        BE_PUSH
    } todlp_back_state_t;

    // One parsed literal, handed from the parser to the arithmetic back end.
    typedef struct packed {
        logic [31:0] hour;
        logic [31:0] minute;
        logic [31:0] second;
        logic [9:0]  millis;
        logic [7:0]  consumed;
        logic        parse_error;
    } todlp_rec_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_L_UP  = 8'h4C;
    localparam logic [7:0] CH_L_LO  = 8'h6C;
    localparam logic [7:0] CH_T_UP  = 8'h54;
    localparam logic [7:0] CH_T_LO  = 8'h74;
    localparam logic [7:0] CH_I_UP  = 8'h49;
    localparam logic [7:0] CH_I_LO  = 8'h69;
    localparam logic [7:0] CH_O_LO  = 8'h6F;
    localparam logic [7:0] CH_D_LO  = 8'h64;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [3:0] LONG_PREFIX_LEN = 4'd12;

    localparam logic [63:0] MUL_SIXTY    = 64'd60;
    localparam logic [63:0] MUL_THOUSAND = 64'd1000;

    localparam int QUEUE_DEPTH = 2;
    localparam int CALC_STEPS  = 5;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_OFFSET : c;
    endfunction

    // Characters of the long prefix in lower case, shifted to upper case on request.
    function automatic logic [7:0] long_prefix_char(input logic upper, input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h6C;
            4'd1:    ch = 8'h74;
            4'd2:    ch = 8'h69;
            4'd3:    ch = 8'h6D;
            4'd4:    ch = 8'h65;
            4'd5:    ch = CH_UNDER;
            4'd6:    ch = 8'h6F;
            4'd7:    ch = 8'h66;
            4'd8:    ch = CH_UNDER;
            4'd9:    ch = 8'h64;
            4'd10:   ch = 8'h61;
            4'd11:   ch = 8'h79;
            default: ch = CH_NUL;
        endcase
        if (upper && (ch != CH_UNDER) && (ch != CH_NUL)) begin
            ch = ch - CASE_OFFSET;
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/todlp_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Time-of-day literal parser front
// Takes one character per cycle while the result queue has room, tracks prefix and
// field parsing, and on the terminator pushes the parsed fields into the queue.
// ---------------------------------------------------------------------------
module todlp_front
    import todlp_pkg::*;
#(
    parameter int MAX_LENGTH = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        push,
    output todlp_rec_t  push_rec,
    input  logic        q_full
);

    localparam int PW = $clog2(MAX_LENGTH + 1);
    localparam int CW = (PW > 8) ? PW : 8;

    todlp_phase_t phase_reg, phase_next;
    todlp_sub_t   sub_reg, sub_next;
    logic [3:0]   pp_reg, pp_next;
    logic [31:0]  hour_reg, hour_next;
    logic [31:0]  min_reg, min_next;
    logic [31:0]  sec_reg, sec_next;
    logic [9:0]   frac_reg, frac_next;
    logic [1:0]   fdig_reg, fdig_next;
    logic [PW-1:0] pos_reg, pos_inc;
    logic [PW-1:0] stop_reg, stop_next;
    logic         stopped_reg, stopped_next;

    logic         accept;
    logic         term;
    logic [7:0]   c;
    logic [7:0]   c_low;
    logic         fld_active;
    todlp_phase_t fphase;
    todlp_sub_t   fsub;
    logic [31:0]  fval;
    logic [35:0]  facc;
    logic [31:0]  fsat;
    logic         real_end;
    logic         sign_ok;
    logic         ok;
    logic [CW-1:0] stop_wide;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_char_code;
    assign c_low   = to_lower(c);
    assign term    = (c == CH_NUL);
    assign pos_inc = (pos_reg < PW'(MAX_LENGTH)) ? pos_reg + 1'b1 : PW'(MAX_LENGTH);

    // Next-state logic for one character.
    always_comb begin
        phase_next   = phase_reg;
        sub_next     = sub_reg;
        pp_next      = pp_reg;
        hour_next    = hour_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        frac_next    = frac_reg;
        fdig_next    = fdig_reg;
        stop_next    = stop_reg;
        stopped_next = stopped_reg;
        fld_active   = 1'b0;
        fphase       = phase_reg;
        fsub         = sub_reg;
        fval         = sec_reg;
        facc         = '0;
        fsat         = '0;
        real_end     = 1'b0;
        sign_ok      = 1'b0;

        if (!stopped_reg && (phase_reg != PH_ERR)) begin
            case (phase_reg)
                PH_START: begin
                    if (c == CH_L_LO) begin
                        phase_next = PH_LO;
                        pp_next    = 4'd1;
                    end else if (c == CH_L_UP) begin
                        phase_next = PH_UP;
                        pp_next    = 4'd1;
                    end else begin
                        // No prefix: this character already belongs to the hour field.
                        fld_active = 1'b1;
                        fphase     = PH_HOUR;
                        fsub       = SUB_INIT;
                        stop_next  = pos_reg;
                    end
                end
                PH_LO, PH_UP: begin
                    if (pp_reg == 4'd1) begin
                        if (c == ((phase_reg == PH_LO) ? CH_T_LO : CH_T_UP)) begin
                            pp_next = 4'd2;
                        end else if (c_low == CH_T_LO) begin
                            phase_next = PH_TOD;
                            pp_next    = 4'd2;
                        end else begin
                            phase_next = PH_ERR;
                        end
                    end else begin
                        if (c_low == CH_O_LO) begin
                            phase_next = PH_TOD;
                            pp_next    = 4'd3;
                        end else if (c == ((phase_reg == PH_LO) ? CH_I_LO : CH_I_UP)) begin
                            phase_next = (phase_reg == PH_LO) ? PH_LONG_LO : PH_LONG_UP;
                            pp_next    = 4'd3;
                        end else begin
                            phase_next = PH_ERR;
                        end
                    end
                end
                PH_TOD: begin
                    if ((pp_reg == 4'd2) && (c_low == CH_O_LO)) begin
                        pp_next = 4'd3;
                    end else if ((pp_reg == 4'd3) && (c_low == CH_D_LO)) begin
                        phase_next = PH_HASH;
                    end else begin
                        phase_next = PH_ERR;
                    end
                end
                PH_LONG_LO, PH_LONG_UP: begin
                    if ((pp_reg < LONG_PREFIX_LEN) &&
                        (c == long_prefix_char(phase_reg == PH_LONG_UP, pp_reg))) begin
                        pp_next = pp_reg + 4'd1;
                        if (pp_reg == LONG_PREFIX_LEN - 4'd1) begin
                            phase_next = PH_HASH;
                        end
                    end else begin
                        phase_next = PH_ERR;
                    end
                end
                PH_HASH: begin
                    if (c == CH_HASH) begin
                        phase_next = PH_HOUR;
                        sub_next   = SUB_INIT;
                        stop_next  = pos_inc;
                    end else begin
                        phase_next = PH_ERR;
                    end
                end
                PH_HOUR, PH_MIN, PH_SEC: begin
                    fld_active = 1'b1;
                end
                PH_FRAC: begin
                    if (is_digit(c)) begin
                        if (fdig_reg < 2'd3) begin
                            frac_next = 10'(frac_reg * 10'd10) + 10'(c[3:0]);
                            fdig_next = fdig_reg + 2'd1;
                        end
                        stop_next = pos_inc;
                    end else begin
                        stopped_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_ERR;
                end
            endcase

            if (fld_active) begin
                phase_next = fphase;
                sub_next   = fsub;
                case (fphase)
                    PH_HOUR: fval = hour_reg;
                    PH_MIN:  fval = min_reg;
                    default: fval = sec_reg;
                endcase
                facc    = 36'({fval, 3'b000}) + 36'({fval, 1'b0}) + 36'(c[3:0]);
                fsat    = (facc[35:32] != 4'd0) ? 32'hFFFF_FFFF : facc[31:0];
                sign_ok = (fsub == SUB_INIT) || (fsub == SUB_BLANK);
                if (is_digit(c)) begin
                    case (fphase)
                        PH_HOUR: hour_next = fsat;
                        PH_MIN:  min_next  = fsat;
                        default: sec_next  = fsat;
                    endcase
                    sub_next  = SUB_DIGIT;
                    stop_next = pos_inc;
                end else if (sign_ok && is_blank(c)) begin
                    sub_next = SUB_BLANK;
                end else if (sign_ok && (c == CH_PLUS)) begin
                    sub_next = SUB_SIGN;
                end else if (sign_ok && (c == CH_MINUS)) begin
                    phase_next = PH_ERR;
                end else begin
                    // The field ends here; blanks or a sign without digits do not count.
                    real_end = (fsub == SUB_INIT) || (fsub == SUB_DIGIT);
                    case (fphase)
                        PH_HOUR: begin
                            if (real_end && (c == CH_COLON)) begin
                                phase_next = PH_MIN;
                                sub_next   = SUB_INIT;
                                stop_next  = pos_inc;
                            end else if (real_end && term && (fsub == SUB_DIGIT)) begin
                                stopped_next = 1'b1;
                            end else begin
                                phase_next = PH_ERR;
                            end
                        end
                        PH_MIN: begin
                            if (real_end && (c == CH_COLON)) begin
                                phase_next = PH_SEC;
                                sub_next   = SUB_INIT;
                                stop_next  = pos_inc;
                            end else begin
                                stopped_next = 1'b1;
                            end
                        end
                        default: begin
                            if (real_end && (c == CH_DOT)) begin
                                phase_next = PH_FRAC;
                                stop_next  = pos_inc;
                            end else begin
                                stopped_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Result record, built from the state after the terminator.
    always_comb begin
        ok        = stopped_next && (phase_next != PH_ERR);
        push      = accept && term;
        stop_wide = CW'(stop_next);
        push_rec  = '0;
        if (ok) begin
            push_rec.hour   = hour_next;
            push_rec.minute = min_next;
            push_rec.second = sec_next;
            case (fdig_next)
                2'd0:    push_rec.millis = 10'd0;
                2'd1:    push_rec.millis = 10'(frac_next * 10'd100);
                2'd2:    push_rec.millis = 10'(frac_next * 10'd10);
                default: push_rec.millis = frac_next;
            endcase
            push_rec.consumed = (stop_wide > CW'(255)) ? 8'hFF : stop_wide[7:0];
        end else begin
            push_rec.parse_error = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && term)) begin
            phase_reg   <= PH_START;
            sub_reg     <= SUB_INIT;
            pp_reg      <= '0;
            hour_reg    <= '0;
            min_reg     <= '0;
            sec_reg     <= '0;
            frac_reg    <= '0;
            fdig_reg    <= '0;
            pos_reg     <= '0;
            stop_reg    <= '0;
            stopped_reg <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            sub_reg     <= sub_next;
            pp_reg      <= pp_next;
            hour_reg    <= hour_next;
            min_reg     <= min_next;
            sec_reg     <= sec_next;
            frac_reg    <= frac_next;
            fdig_reg    <= fdig_next;
            pos_reg     <= pos_inc;
            stop_reg    <= stop_next;
            stopped_reg <= stopped_next;
        end
    end

    // A parse can only stop inside a numeric field, never after an error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> (phase_reg == PH_HOUR) || (phase_reg == PH_MIN) ||
                        (phase_reg == PH_SEC) || (phase_reg == PH_FRAC))
        else $error("parse stopped outside a numeric field");

    // Every terminator restarts the parser for the next string.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && term) |=> (phase_reg == PH_START) && (pos_reg == '0) && !stopped_reg)
        else $error("parser did not restart after terminator");

endmodule
`default_nettype wire

/* rtl/core/todlp_queue.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Time-of-day literal parser result queue
// Short first-in first-out buffer of parsed records between the parser and
// the arithmetic back end.
// ---------------------------------------------------------------------------
module todlp_queue
    import todlp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  todlp_rec_t push_rec,
    input  logic       pop,
    output todlp_rec_t head,
    output logic       full,
    output logic       empty
);

    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    todlp_rec_t     entry_reg [QUEUE_DEPTH];
    logic [QIW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == QCW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QIW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QIW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/todlp_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Time-of-day literal parser back end
// Converts a parsed record to nanoseconds with one shared multiply-add unit
// stepped over several cycles, and holds the result in the output register.
// ---------------------------------------------------------------------------
module todlp_back
    import todlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  todlp_rec_t  head,
    input  logic        empty,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value_ns,
    output logic [7:0]  m_consumed,
    output logic        m_parse_error
);

    localparam logic [2:0] LAST_STEP = 3'(CALC_STEPS - 1);

    todlp_back_state_t state_reg, state_next;
    todlp_rec_t        rec_reg;
    logic [63:0]       acc_reg;
    logic [2:0]        step_reg;
    logic              m_valid_reg;
    logic [63:0]       m_value_ns_reg;
    logic [7:0]        m_consumed_reg;
    logic              m_parse_error_reg;

    logic              out_free;
    logic              load_out;
    logic [63:0]       scaled;
    logic [63:0]       addend;
    logic [63:0]       mac;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE: begin
                if (!empty) begin
                    state_next = BE_CALC;
                end
            end
            BE_CALC: begin
                if (step_reg == LAST_STEP) begin
                    state_next = BE_PUSH;
                end
            end
            BE_PUSH: begin
                if (out_free) begin
                    state_next = BE_IDLE;
                end
            end
            default: begin
                state_next = BE_IDLE;
            end
        endcase
    end

    // Steps: hour*60+min, *60+sec, *1000+ms, *1000, *1000.
    always_comb begin
        pop      = (state_reg == BE_IDLE) && !empty;
        load_out = (state_reg == BE_PUSH) && out_free;
        // One factor is a constant, so each product is a few shifted adds.
        scaled   = (step_reg < 3'd2) ? 64'(acc_reg * MUL_SIXTY) : 64'(acc_reg * MUL_THOUSAND);
        case (step_reg)
            3'd0:    addend = 64'(rec_reg.minute);
            3'd1:    addend = 64'(rec_reg.second);
            3'd2:    addend = 64'(rec_reg.millis);
            default: addend = '0;
        endcase
        mac = scaled + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BE_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                step_reg <= '0;
            end else if (state_reg == BE_CALC) begin
                step_reg <= step_reg + 3'd1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= head;
            acc_reg <= 64'(head.hour);
        end else if (state_reg == BE_CALC) begin
            acc_reg <= mac;
        end
        if (load_out) begin
            m_value_ns_reg    <= acc_reg;
            m_consumed_reg    <= rec_reg.consumed;
            m_parse_error_reg <= rec_reg.parse_error;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value_ns    = m_value_ns_reg;
    assign m_consumed    = m_consumed_reg;
    assign m_parse_error = m_parse_error_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BE_CALC) |-> (step_reg <= LAST_STEP))
        else $error("multiply-add step counter ran past the last step");

    // Malformed literals always report zero time and zero length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_parse_error_reg) |-> (m_value_ns_reg == '0) && (m_consumed_reg == '0))
        else $error("error result carries a nonzero value");

    // A finished result waits in place while the output register is still occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == BE_PUSH) && m_valid_reg && !m_ready) |=>
            (state_reg == BE_PUSH) && m_valid_reg)
        else $error("result lost while the receiver stalled");

endmodule
`default_nettype wire

/* rtl/core/time_of_day_literal_parser.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// Time-of-day literal parser
// Streams a time-of-day literal one character per transfer on the s_ channel
// (zero byte ends the string) and returns one transfer on the m_ channel per
// string: time in nanoseconds, characters consumed and an error flag.
//
// The parser front takes one character per cycle while the two-entry result
// queue has room. On the terminator the parsed fields enter the queue; the
// back end pops them and runs five multiply-add steps on one shared 64-bit
// unit, then loads the result into the output register behind m_valid. It
// pops the next record only once the last result has gone to that register,
// so short strings arriving back to back fill the queue and s_ready drops
// until the back end catches up.
// A stalled receiver holds the result in the output register; the back end
// then waits with the next result and the queue absorbs further strings.
// Reset (aresetn low, synchronous) empties the queue, drops m_valid and
// returns the parser to the start of a string.
// ---------------------------------------------------------------------------
module time_of_day_literal_parser
    import todlp_pkg::*;
#(
    parameter int MAX_LENGTH = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value_ns,
    output logic [7:0]  m_consumed,
    output logic        m_parse_error
);

    logic       push;
    todlp_rec_t push_rec;
    logic       q_full;
    logic       q_empty;
    logic       pop;
    todlp_rec_t head;

    todlp_front #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .push        (push),
        .push_rec    (push_rec),
        .q_full      (q_full)
    );

    todlp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    todlp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_ns    (m_value_ns),
        .m_consumed    (m_consumed),
        .m_parse_error (m_parse_error)
    );

endmodule
`default_nettype wire
